>>> hdl/slpd_pkg.sv
// ----------------------------------------------------------------------------
// slpd_pkg
// Shared types and constants for the sync/length packet deframer.
// ----------------------------------------------------------------------------
package slpd_pkg;

  localparam int unsigned CfgWidth = 16;
  localparam int unsigned CfgIndexWidth = 2;

  localparam logic [15:0] SYNC_WORD_RESET = 16'hAA55;
  localparam logic [15:0] ACK_CODE_RESET = 16'h0007;
  localparam logic [15:0] HELLO_ACK_CODE_RESET = 16'h0005;
  localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd100;

  localparam logic [3:0] HDR_BYTES = 4'd11;
  localparam logic [3:0] HDR_FIRST_INDEX = 4'd2;
  localparam logic [3:0] HDR_LAST_INDEX = HDR_BYTES - 4'd1;

  // configuration register indexes
  localparam logic [CfgIndexWidth-1:0] REG_SYNC_WORD = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_ACK_CODE = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_HELLO_ACK_CODE = 2'd2;
  localparam logic [CfgIndexWidth-1:0] REG_ACK_TIMEOUT = 2'd3;

  // input modes
  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_ARM = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ACK = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] packet_type;
    logic [15:0] module_code;
    logic [31:0] payload_length;
    logic [7:0]  data_byte;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] sync_word;
    logic [15:0] ack_code;
    logic [15:0] hello_ack_code;
    logic [15:0] ack_timeout_ticks;
  } cfg_t;

endpackage

>>> hdl/slpd_cfg.sv
// ----------------------------------------------------------------------------
// slpd_cfg
// Configuration register file: sync word, acknowledge codes, timeout.
// ----------------------------------------------------------------------------
module slpd_cfg
  import slpd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]      cfg_data,
  output cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_word <= SYNC_WORD_RESET;
      cfg.ack_code <= ACK_CODE_RESET;
      cfg.hello_ack_code <= HELLO_ACK_CODE_RESET;
      cfg.ack_timeout_ticks <= ACK_TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SYNC_WORD: cfg.sync_word <= cfg_data;
        REG_ACK_CODE: cfg.ack_code <= cfg_data;
        REG_HELLO_ACK_CODE: cfg.hello_ack_code <= cfg_data;
        REG_ACK_TIMEOUT: cfg.ack_timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/slpd_core.sv
// ----------------------------------------------------------------------------
// slpd_core
// Deframer state machine and result register: sync hunt, header capture,
// payload count, acknowledge wait and timeout.
// ----------------------------------------------------------------------------
module slpd_core
  import slpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      item_valid,
  input  in_item_t  item,
  output logic      item_take,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  prev_byte, prev_byte_next;
  logic        prev_valid, prev_valid_next;
  logic [3:0]  header_index, header_index_next;
  logic [15:0] held_type, held_type_next;
  logic [15:0] held_module, held_module_next;
  logic [31:0] held_length, held_length_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic        is_ack_packet, is_ack_packet_next;
  logic        waiting_ack, waiting_ack_next;
  logic [15:0] ticks_waited, ticks_waited_next;

  logic        res_valid;
  out_item_t   res;
  logic [31:0] remaining_dec;
  logic [15:0] ticks_inc;
  logic        type_is_ack;

  assign item_take = item_valid && (!out_valid || !out_stall);
  assign remaining_dec = bytes_remaining - 32'd1;
  assign ticks_inc = (ticks_waited != 16'hFFFF) ? ticks_waited + 16'd1 : ticks_waited;
  assign type_is_ack = (held_type == cfg.ack_code) || (held_type == cfg.hello_ack_code);

  always_comb begin
    phase_next = phase;
    prev_byte_next = prev_byte;
    prev_valid_next = prev_valid;
    header_index_next = header_index;
    held_type_next = held_type;
    held_module_next = held_module;
    held_length_next = held_length;
    bytes_remaining_next = bytes_remaining;
    is_ack_packet_next = is_ack_packet;
    waiting_ack_next = waiting_ack;
    ticks_waited_next = ticks_waited;
    res_valid = 1'b0;
    res = '0;

    case (item.mode)
      MODE_BYTE: begin
        unique case (phase)
          PH_HEADER: begin
            if (header_index == 4'd3 || header_index == 4'd4) begin
              held_type_next = {held_type[7:0], item.rx_byte};
            end else if (header_index == 4'd5 || header_index == 4'd6) begin
              held_module_next = {held_module[7:0], item.rx_byte};
            end else if (header_index >= 4'd7 && header_index <= HDR_LAST_INDEX) begin
              held_length_next = {held_length[23:0], item.rx_byte};
            end
            header_index_next = header_index + 4'd1;
            if (header_index >= HDR_LAST_INDEX) begin
              is_ack_packet_next = type_is_ack;
              bytes_remaining_next = held_length_next;
              res.packet_type = held_type;
              res.module_code = held_module;
              res.payload_length = held_length_next;
              if (held_length_next == 32'd0) begin
                phase_next = PH_HUNT;
                prev_valid_next = 1'b0;
                prev_byte_next = 8'd0;
                if (!type_is_ack) begin
                  res_valid = 1'b1;
                  res.kind = KIND_HEADER;
                  res.last = 1'b1;
                end else if (waiting_ack) begin
                  res_valid = 1'b1;
                  res.kind = KIND_ACK;
                  waiting_ack_next = 1'b0;
                  ticks_waited_next = 16'd0;
                end
              end else begin
                phase_next = PH_PAYLOAD;
                if (!type_is_ack) begin
                  res_valid = 1'b1;
                  res.kind = KIND_HEADER;
                end
              end
            end
          end
          PH_PAYLOAD: begin
            bytes_remaining_next = remaining_dec;
            res.packet_type = held_type;
            res.module_code = held_module;
            res.payload_length = held_length;
            if (remaining_dec == 32'd0) begin
              phase_next = PH_HUNT;
              prev_valid_next = 1'b0;
              prev_byte_next = 8'd0;
            end
            if (!is_ack_packet) begin
              res_valid = 1'b1;
              res.kind = KIND_PAYLOAD;
              res.data_byte = item.rx_byte;
              res.last = (remaining_dec == 32'd0);
            end else if (remaining_dec == 32'd0 && waiting_ack) begin
              res_valid = 1'b1;
              res.kind = KIND_ACK;
              waiting_ack_next = 1'b0;
              ticks_waited_next = 16'd0;
            end
          end
          default: begin
            if (prev_valid && ({prev_byte, item.rx_byte} == cfg.sync_word)) begin
              phase_next = PH_HEADER;
              header_index_next = HDR_FIRST_INDEX;
              held_type_next = 16'd0;
              held_module_next = 16'd0;
              held_length_next = 32'd0;
              prev_valid_next = 1'b0;
              prev_byte_next = 8'd0;
            end else begin
              prev_byte_next = item.rx_byte;
              prev_valid_next = 1'b1;
            end
          end
        endcase
      end
      MODE_ARM: begin
        waiting_ack_next = 1'b1;
        ticks_waited_next = 16'd0;
      end
      MODE_TICK: begin
        if (waiting_ack) begin
          if (ticks_inc >= cfg.ack_timeout_ticks) begin
            waiting_ack_next = 1'b0;
            ticks_waited_next = 16'd0;
            res_valid = 1'b1;
            res.kind = KIND_TIMEOUT;
          end else begin
            ticks_waited_next = ticks_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      prev_byte <= 8'd0;
      prev_valid <= 1'b0;
      header_index <= 4'd0;
      held_type <= 16'd0;
      held_module <= 16'd0;
      held_length <= 32'd0;
      bytes_remaining <= 32'd0;
      is_ack_packet <= 1'b0;
      waiting_ack <= 1'b0;
      ticks_waited <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      if (item_take) begin
        phase <= phase_next;
        prev_byte <= prev_byte_next;
        prev_valid <= prev_valid_next;
        header_index <= header_index_next;
        held_type <= held_type_next;
        held_module <= held_module_next;
        held_length <= held_length_next;
        bytes_remaining <= bytes_remaining_next;
        is_ack_packet <= is_ack_packet_next;
        waiting_ack <= waiting_ack_next;
        ticks_waited <= ticks_waited_next;
        out_valid <= res_valid;
        if (res_valid) begin
          out_data <= res;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> bytes_remaining != 32'd0)
    else $error("payload phase with no bytes remaining");

  a_header_index_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> header_index >= HDR_FIRST_INDEX && header_index <= HDR_LAST_INDEX)
    else $error("header index out of range");

  a_idle_ticks_clear: assert property (@(posedge clk) disable iff (rst)
    !waiting_ack |-> ticks_waited == 16'd0)
    else $error("tick count held while not waiting");

  a_ack_disarms: assert property (@(posedge clk) disable iff (rst)
    item_take && res_valid && (res.kind == KIND_ACK || res.kind == KIND_TIMEOUT)
      |=> !waiting_ack)
    else $error("wait still armed after acknowledge or timeout");

endmodule

>>> hdl/sync_length_packet_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_packet_deframer
// Byte-stream deframer: sync hunt, 11-byte header, payload and ack timeout.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while out_stall is low: a received byte, an
// arm of the acknowledge wait, or a timer tick. Each transaction is registered
// on input and resolved by the header/payload state machine, whose result
// lands in an output register. Data packets give a header result and one
// result per payload byte (final one marked last, the header itself when the
// length is zero); acknowledge packets are swallowed and report acknowledged
// only when a wait is armed. The user must write registers through
// cfg_write/cfg_index/cfg_data only while the block is idle; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module sync_length_packet_deframer
  import slpd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]      cfg_data
);

  cfg_t     cfg;
  logic     item_valid;
  in_item_t item;
  logic     item_take;

  assign in_stall = item_valid && !item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
      if (in_valid) begin
        item <= in_data;
      end
    end
  end

  slpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slpd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

>>> tb/sync_length_packet_deframer_tb.sv
// ----------------------------------------------------------------------------
// sync_length_packet_deframer_tb
// Self-checking bench for the sync/length packet deframer.
// ----------------------------------------------------------------------------
// Feeds byte, arm, tick and unused-mode transactions: framed data and acknowledge
// packets with random content, stray bytes, half sync words and timer traffic. A
// scoreboard tracks the deframer state from the accepted transactions, keeps
// the results it predicts in order and checks every output transaction field
// by field. Runs through several register settings, the extremes included,
// with random idling on both sides, a gap-free stretch, a long output hold-off
// and full drains.
// ----------------------------------------------------------------------------
module sync_length_packet_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slpd_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    SEEK,
    IN_HEADER,
    IN_PAYLOAD
  } deframe_phase_t;

  class deframe_scoreboard;
    logic [15:0]    sync_word;
    logic [15:0]    ack_code;
    logic [15:0]    hello_code;
    logic [15:0]    timeout_ticks;
    deframe_phase_t phase;
    logic [7:0]     prev_byte;
    logic           prev_valid;
    logic [3:0]     hdr_idx;
    logic [15:0]    cur_type;
    logic [15:0]    cur_module;
    logic [31:0]    cur_len;
    logic [31:0]    remaining;
    logic           ack_pkt;
    logic           armed;
    logic [15:0]    ticks;
    out_item_t      expected[$];
    int             errors;

    function new();
      sync_word     = SYNC_WORD_RESET;
      ack_code      = ACK_CODE_RESET;
      hello_code    = HELLO_ACK_CODE_RESET;
      timeout_ticks = ACK_TIMEOUT_RESET;
      phase         = SEEK;
      prev_byte     = '0;
      prev_valid    = 1'b0;
      hdr_idx       = '0;
      cur_type      = '0;
      cur_module    = '0;
      cur_len       = '0;
      remaining     = '0;
      ack_pkt       = 1'b0;
      armed         = 1'b0;
      ticks         = '0;
      errors        = 0;
    endfunction

    function void set_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgWidth-1:0] val);
      case (idx)
        REG_SYNC_WORD:      sync_word = val;
        REG_ACK_CODE:       ack_code = val;
        REG_HELLO_ACK_CODE: hello_code = val;
        REG_ACK_TIMEOUT:    timeout_ticks = val;
        default: ;
      endcase
    endfunction

    function void push_result(logic [1:0] kind, logic [7:0] b, logic last);
      out_item_t r;
      r.kind           = kind;
      r.packet_type    = cur_type;
      r.module_code    = cur_module;
      r.payload_length = cur_len;
      r.data_byte      = b;
      r.last           = last;
      expected.insert(expected.size(), r);
    endfunction

    function void close_packet();
      phase      = SEEK;
      prev_valid = 1'b0;
      prev_byte  = '0;
    endfunction

    function void finish_ack();
      close_packet();
      if (armed) begin
        armed = 1'b0;
        ticks = '0;
        push_result(KIND_ACK, 8'h00, 1'b0);
      end
    endfunction

    function void take_byte(logic [7:0] b);
      logic last_hdr;
      case (phase)
        IN_HEADER: begin
          if (hdr_idx == 4'd3 || hdr_idx == 4'd4) cur_type = {cur_type[7:0], b};
          else if (hdr_idx == 4'd5 || hdr_idx == 4'd6) cur_module = {cur_module[7:0], b};
          else if (hdr_idx >= 4'd7 && hdr_idx <= 4'd10) cur_len = {cur_len[23:0], b};
          last_hdr = (hdr_idx == HDR_LAST_INDEX);
          hdr_idx = hdr_idx + 4'd1;
          if (!last_hdr) return;
          ack_pkt   = (cur_type == ack_code) || (cur_type == hello_code);
          remaining = cur_len;
          if (ack_pkt) begin
            if (cur_len == 0) finish_ack();
            else phase = IN_PAYLOAD;
          end else if (cur_len == 0) begin
            close_packet();
            push_result(KIND_HEADER, 8'h00, 1'b1);
          end else begin
            phase = IN_PAYLOAD;
            push_result(KIND_HEADER, 8'h00, 1'b0);
          end
        end
        IN_PAYLOAD: begin
          remaining = remaining - 32'd1;
          if (ack_pkt) begin
            if (remaining == 0) finish_ack();
          end else if (remaining == 0) begin
            close_packet();
            push_result(KIND_PAYLOAD, b, 1'b1);
          end else begin
            push_result(KIND_PAYLOAD, b, 1'b0);
          end
        end
        default: begin
          if (prev_valid && {prev_byte, b} == sync_word) begin
            phase      = IN_HEADER;
            hdr_idx    = HDR_FIRST_INDEX;
            cur_type   = '0;
            cur_module = '0;
            cur_len    = '0;
            prev_valid = 1'b0;
            prev_byte  = '0;
          end else begin
            prev_byte  = b;
            prev_valid = 1'b1;
          end
        end
      endcase
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      case (it.mode)
        MODE_BYTE: take_byte(it.rx_byte);
        MODE_ARM: begin
          armed = 1'b1;
          ticks = '0;
        end
        MODE_TICK: begin
          if (armed) begin
            if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
            if (ticks >= timeout_ticks) begin
              armed  = 1'b0;
              ticks  = '0;
              r      = '0;
              r.kind = KIND_TIMEOUT;
              expected.insert(expected.size(), r);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected.size() == 0) begin
        $error("unexpected result: kind %0d type 0x%0h data 0x%0h",
               got.kind, got.packet_type, got.data_byte);
        errors++;
        return;
      end
      want = expected.pop_front();
      field_check("kind", 32'(want.kind), 32'(got.kind));
      field_check("packet_type", 32'(want.packet_type), 32'(got.packet_type));
      field_check("module_code", 32'(want.module_code), 32'(got.module_code));
      field_check("payload_length", want.payload_length, got.payload_length);
      field_check("data_byte", 32'(want.data_byte), 32'(got.data_byte));
      field_check("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_data;
  logic                     cfg_write = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgWidth-1:0]      cfg_data = '0;

  deframe_scoreboard sb;
  bit                in_gaps = 1'b1;
  bit                out_gaps = 1'b1;
  int                hold_requests = 0;
  int                holds_done = 0;
  int                items_sent = 0;

  sync_length_packet_deframer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // transaction monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_input(in_data);
    end
  end

  // output side: random stalls, plus long hold-offs on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else begin
        out_stall <= out_gaps && ($urandom_range(99) < 35);
      end
    end
  end

  task automatic send(logic [1:0] mode, logic [7:0] b);
    while (in_gaps && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {mode, b};
    if (mode != MODE_UNUSED) items_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_byte(logic [7:0] b);
    send(MODE_BYTE, b);
  endtask

  task automatic maybe_interject();
    int r;
    r = $urandom_range(99);
    if (r < 3) send(MODE_ARM, 8'($urandom_range(255)));
    else if (r < 7) send(MODE_TICK, 8'($urandom_range(255)));
    else if (r < 8) send(MODE_UNUSED, 8'($urandom_range(255)));
  endtask

  // stray byte that can never take part in a sync match
  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == sb.sync_word[15:8] || b == sb.sync_word[7:0]);
    return b;
  endfunction

  function automatic logic [15:0] pick_type();
    int r;
    r = $urandom_range(99);
    if (r < 20) return sb.ack_code;
    if (r < 35) return sb.hello_code;
    return 16'($urandom_range(16'hFFFF));
  endfunction

  function automatic logic [15:0] data_type();
    logic [15:0] t;
    do t = 16'($urandom_range(16'hFFFF));
    while (t == sb.ack_code || t == sb.hello_code);
    return t;
  endfunction

  function automatic logic [15:0] pick_module();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'h0000;
    if (r < 20) return 16'hFFFF;
    return 16'($urandom_range(16'hFFFF));
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 0;
    if (r < 85) return $urandom_range(1, 8);
    return $urandom_range(9, 40);
  endfunction

  task automatic send_header(logic [7:0] ver, logic [15:0] ptype, logic [15:0] pmod,
                             logic [31:0] len, bit noisy);
    logic [87:0] hdr;
    hdr = {sb.sync_word, ver, ptype, pmod, len};
    // repeated first sync byte: the hunt must slide by one
    if (noisy && sb.sync_word[15:8] != sb.sync_word[7:0] && $urandom_range(9) == 0)
      send_byte(sb.sync_word[15:8]);
    for (int i = 0; i < 11; i++) begin
      send_byte(hdr[87 - 8*i -: 8]);
      if (noisy) maybe_interject();
    end
  endtask

  task automatic send_packet(logic [15:0] ptype, logic [31:0] len, int n_payload, bit noisy);
    send_header(8'($urandom_range(255)), ptype, pick_module(), len, noisy);
    repeat (n_payload) begin
      send_byte(8'($urandom_range(255)));
      if (noisy) maybe_interject();
    end
  endtask

  task automatic random_traffic(int target);
    int stop;
    int r;
    int len;
    stop = items_sent + target;
    while (items_sent < stop) begin
      r = $urandom_range(99);
      if (r < 65) begin
        len = pick_len();
        send_packet(pick_type(), len, len, 1'b1);
      end else if (r < 75) begin
        send(MODE_ARM, 8'($urandom_range(255)));
      end else if (r < 85) begin
        repeat ($urandom_range(1, 12)) send(MODE_TICK, 8'($urandom_range(255)));
      end else if (r < 92) begin
        repeat ($urandom_range(1, 4)) send_byte(junk_byte());
      end else if (r < 97) begin
        // half sync word
        send_byte(sb.sync_word[15:8]);
        send_byte(junk_byte());
      end else begin
        send(MODE_UNUSED, 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgWidth-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] sync_w, logic [15:0] ack_c, logic [15:0] hello_c,
                            logic [15:0] ticks);
    wait_idle();
    write_reg(REG_SYNC_WORD, sync_w);
    write_reg(REG_ACK_CODE, ack_c);
    write_reg(REG_HELLO_ACK_CODE, hello_c);
    write_reg(REG_ACK_TIMEOUT, ticks);
    cfg_write <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset settings
    send(MODE_UNUSED, 8'hFF);
    send(MODE_TICK, 8'h00);
    send_byte(8'h00);
    send_header(8'hFF, 16'hFFFF, 16'hFFFF, 32'h0, 1'b0);
    send(MODE_ARM, 8'h00);
    send_header(8'h00, ACK_CODE_RESET, 16'h0000, 32'h0, 1'b0);
    send(MODE_ARM, 8'h00);
    send_header(8'h00, HELLO_ACK_CODE_RESET, 16'h1234, 32'd1, 1'b0);
    send_byte(8'hFF);

    // shortest timeout, re-arm while armed
    set_config(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
               16'($urandom_range(16'hFFFF)), 16'd1);
    send(MODE_ARM, 8'h00);
    send(MODE_TICK, 8'h00);
    send(MODE_ARM, 8'h00);
    send(MODE_ARM, 8'h00);
    send(MODE_TICK, 8'h00);
    send(MODE_TICK, 8'h00);
    random_traffic(220);

    set_config(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    random_traffic(200);

    // gap-free stretch
    set_config(16'hFFFF, 16'h0000, 16'hFFFF, 16'($urandom_range(2, 20)));
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    random_traffic(200);
    in_gaps  = 1'b1;
    out_gaps = 1'b1;

    set_config(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
               16'($urandom_range(16'hFFFF)), 16'($urandom_range(1, 10)));
    random_traffic(100);
    hold_requests++;
    send_packet(data_type(), 32'd60, 60, 1'b0);
    wait_idle();
    random_traffic(120);

    // huge length, left open at the end of the run
    send_packet(data_type(), 32'hFFFF_FFFF, 5, 1'b0);
    wait_idle();
    repeat (10) @(posedge clk);

    if (sb.errors == 0) begin
      $display("sync_length_packet_deframer verification clean");
    end else begin
      $display("sync_length_packet_deframer verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("sync_length_packet_deframer verification failed");
    $finish;
  end

endmodule
